// ===== src/ucb_peer_selector_with_breaker_unit_macros.svh =====
// Assertion macros shared by the peer selector RTL.
`ifndef UCB_PEER_SELECTOR_WITH_BREAKER_UNIT_MACROS_SVH
`define UCB_PEER_SELECTOR_WITH_BREAKER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define UCB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define UCB_ASSERT(lbl, prop, msg)
`define UCB_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== src/ucb_pkg.sv =====
// Shared types and constants of the peer selector.
package ucb_pkg;
  localparam int unsigned MAX_PEERS_DEF = 32;
  localparam int unsigned RTT_W  = 24;
  localparam int unsigned SUCC_W = 17;
  localparam int unsigned INFL_W = 8;
  localparam int unsigned STRK_W = 8;
  localparam int unsigned CALL_W = 32;
  localparam int unsigned TRIP_W = 32;
  localparam int unsigned LNQ_W  = 16;
  localparam int unsigned SQRT_W = 24;
  localparam int unsigned ROOT_W = 12;
  localparam int unsigned SCORE_W = 30;
  localparam int unsigned ES_W   = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [23:0] LN2_Q24     = 24'd11629080;
  localparam logic [23:0] RTT_EMPTY   = 24'd25600;
  localparam logic [16:0] SUCC_ONE    = 17'd65536;
  localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEER_COUNT       = 2'd0,
    REG_IN_FLIGHT_LIMIT  = 2'd1,
    REG_EXPLORE_STRENGTH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [TRIP_W-1:0] trip;
    logic [CALL_W-1:0] calls;
    logic [STRK_W-1:0] streak;
    logic [INFL_W-1:0] infl;
    logic [SUCC_W-1:0] succ;
    logic [RTT_W-1:0]  rtt;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{trip: '0, calls: '0, streak: '0, infl: '0,
                                     succ: SUCC_ONE, rtt: '0};

  // Handshake between the sequencer and an iterative unit.
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;
endpackage

// ===== src/ucb_peer_selector_with_breaker_unit.sv =====
// Top level of the UCB1 peer selector with per-peer circuit breaker.
//
//  channel | direction | contents
//  s_axis  | in        | tuser: mode; tdata: peer_index, done_ok, rtt_sample, now_seconds
//  m_axis  | out       | tuser: found; tdata: chosen_peer
//  cfg     | in        | write enable, register index, data
//
// A completion report passes through ST_RP_CALC and ST_RP_WR back to idle; a report
// for an unused index is dropped while idle. A pick sums the call totals, runs the
// logarithm, then scores the peers in use: the single table memory
// port is read once per peer for the call total and again for scoring, and each
// available peer runs the bit-serial divider and square root.
// Reset clears all control state; table entries read as their reset value until
// first written, tracked by one valid bit per entry.
// A pick waits in its last cycle while the previous result has not been taken.
module ucb_peer_selector_with_breaker_unit #(
  parameter int unsigned MAX_PEERS = ucb_pkg::MAX_PEERS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [63:0]                       s_axis_tdata_i,  // peer_index, done_ok, rtt_sample, now_seconds
  input  logic                              s_axis_tuser_i,  // mode
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,  // chosen_peer
  output logic                              m_axis_tuser_o,  // found
  input  logic                              cfg_we_i,
  input  logic [ucb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ucb_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ucb_pkg::*;
  `include "ucb_peer_selector_with_breaker_unit_macros.svh"

  localparam int unsigned PIW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int unsigned CW  = $clog2(MAX_PEERS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM_RD, ST_SUM_ACC, ST_LN, ST_SC_RD, ST_SC_CHK, ST_SC_WAIT,
    ST_PICK_OUT, ST_RP_CALC, ST_RP_WR
  } top_state_e;

  top_state_e state_q;

  // Configuration.
  logic [5:0]      peer_count_q;
  logic [7:0]      limit_q;
  logic [ES_W-1:0] explore_q;

  // Latched input item.
  logic [4:0]  idx_q;
  logic        ok_q;
  logic [23:0] sample_q;
  logic [31:0] now_q;

  logic [CW-1:0]  cnt_q;
  logic [31:0]    pull_total_q;
  logic [PIW-1:0] rd_addr_q;
  logic [MAX_PEERS-1:0] valid_q;
  entry_t         cur_ent_q;
  entry_t         best_ent_q;
  logic [PIW-1:0] best_idx_q;
  logic           best_found_q;
  logic signed [SCORE_W-1:0] best_score_q;
  entry_t         upd_q;
  entry_t         upd_d;
  logic [27:0]    mix_q;
  logic           ln_start_q;

  logic           m_valid_q;
  logic           m_found_q;
  logic [4:0]     m_peer_q;

  // Memory port and unit wiring.
  logic                    ram_we;
  logic [PIW-1:0]          ram_waddr;
  entry_t                  ram_wdata;
  logic                    ram_re;
  logic [PIW-1:0]          ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                  ent_rd;

  unit_req_t  ln_req;
  unit_stat_t ln_stat;
  logic [LNQ_W-1:0] lnq;
  unit_req_t  sc_req;
  unit_stat_t sc_stat;
  logic signed [SCORE_W-1:0] score;

  logic [CW-1:0] n_peers;
  logic          in_fire;
  logic [4:0]    in_idx;
  logic          in_idx_ok;
  logic          avail;
  logic          out_free;
  logic [32:0]   sum_ext;
  logic [STRK_W-1:0] streak_n;
  logic [11:0]   backoff_raw;
  logic [8:0]    backoff;
  logic [32:0]   trip_ext;
  logic [59:0]   div10_p;

  assign n_peers = (32'(peer_count_q) > MAX_PEERS) ? CW'(MAX_PEERS) : CW'(peer_count_q);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_idx    = s_axis_tdata_i[4:0];
  assign in_idx_ok = (32'(in_idx) < 32'(n_peers));
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free  = !m_valid_q || m_axis_tready_i;

  // An entry never written reads as its reset value.
  assign ent_rd = valid_q[rd_addr_q] ? entry_t'(ram_rdata) : ENTRY_RESET;

  // A peer is usable when its breaker is not open and it has a free slot.
  assign avail = !((ent_rd.trip != '0) && (now_q < ent_rd.trip)) && (ent_rd.infl < limit_q);

  assign sum_ext = 33'(pull_total_q) + 33'(ent_rd.calls);

  always_comb begin
    streak_n    = (ent_rd.streak == '1) ? ent_rd.streak : ent_rd.streak + 8'd1;
    backoff_raw = 12'(streak_n) * 12'd15;
    backoff     = (backoff_raw > 12'd300) ? 9'd300 : backoff_raw[8:0];
    trip_ext    = 33'(now_q) + 33'(backoff);
    div10_p     = 60'(mix_q) * 60'(DIV10_RECIP);
  end

  // Entry after a completion report, apart from the RTT average.
  always_comb begin
    upd_d       = ent_rd;
    upd_d.infl  = (ent_rd.infl != '0) ? ent_rd.infl - 8'd1 : ent_rd.infl;
    upd_d.calls = (ent_rd.calls == '1) ? ent_rd.calls : ent_rd.calls + 32'd1;
    upd_d.succ  = SUCC_W'((20'(ent_rd.succ) * 20'd3
                           + (ok_q ? 20'd65536 : 20'd0)) >> 2);
    if (ok_q) begin
      upd_d.streak = '0;
      upd_d.trip   = '0;
    end else begin
      upd_d.streak = streak_n;
      if (streak_n >= 8'd3) begin
        upd_d.trip = trip_ext[32] ? 32'hFFFFFFFF : trip_ext[31:0];
      end
    end
  end

  assign ln_req.start = ln_start_q;
  assign sc_req.start = (state_q == ST_SC_CHK) && avail;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cnt_q[PIW-1:0];
    ram_we    = 1'b0;
    ram_waddr = best_idx_q;
    ram_wdata = best_ent_q;
    ram_wdata.infl = best_ent_q.infl + 8'd1;
    unique case (state_q)
      ST_IDLE: begin
        ram_re    = in_fire && s_axis_tuser_i && in_idx_ok;
        ram_raddr = PIW'(in_idx);
      end
      ST_SUM_RD, ST_SC_RD: begin
        ram_re = (cnt_q < n_peers);
      end
      ST_PICK_OUT: begin
        ram_we = out_free && best_found_q;
      end
      ST_RP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = PIW'(idx_q);
        ram_wdata = upd_q;
        if (sample_q != '0) begin
          ram_wdata.rtt = (upd_q.rtt == '0) ? sample_q : RTT_W'(div10_p >> 35);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      peer_count_q <= '0;
      limit_q      <= 8'd4;
      explore_q    <= 24'd51200;
      idx_q        <= '0;
      ok_q         <= 1'b0;
      sample_q     <= '0;
      now_q        <= '0;
      cnt_q        <= '0;
      pull_total_q <= '0;
      rd_addr_q    <= '0;
      valid_q      <= '0;
      cur_ent_q    <= ENTRY_RESET;
      best_ent_q   <= ENTRY_RESET;
      best_idx_q   <= '0;
      best_found_q <= 1'b0;
      best_score_q <= '0;
      upd_q        <= ENTRY_RESET;
      mix_q        <= '0;
      ln_start_q   <= 1'b0;
      m_valid_q    <= 1'b0;
      m_found_q    <= 1'b0;
      m_peer_q     <= '0;
    end else begin
      ln_start_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PEER_COUNT:       peer_count_q <= cfg_data_i[5:0];
          REG_IN_FLIGHT_LIMIT:  limit_q      <= cfg_data_i[7:0];
          REG_EXPLORE_STRENGTH: explore_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (ram_re) begin
        rd_addr_q <= ram_raddr;
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            idx_q    <= in_idx;
            ok_q     <= s_axis_tdata_i[5];
            sample_q <= s_axis_tdata_i[29:6];
            now_q    <= s_axis_tdata_i[61:30];
            cnt_q    <= '0;
            if (!s_axis_tuser_i) begin
              pull_total_q <= '0;
              best_found_q <= 1'b0;
              state_q      <= ST_SUM_RD;
            end else if (in_idx_ok) begin
              state_q <= ST_RP_CALC;
            end
          end
        end
        ST_SUM_RD: begin
          if (cnt_q < n_peers) begin
            state_q <= ST_SUM_ACC;
          end else begin
            ln_start_q <= 1'b1;
            state_q    <= ST_LN;
          end
        end
        ST_SUM_ACC: begin
          // Saturating total of the call counts of the peers in use.
          pull_total_q <= sum_ext[32] ? 32'hFFFFFFFF : sum_ext[31:0];
          cnt_q        <= cnt_q + CW'(1);
          state_q      <= ST_SUM_RD;
        end
        ST_LN: begin
          if (ln_stat.done) begin
            cnt_q   <= '0;
            state_q <= ST_SC_RD;
          end
        end
        ST_SC_RD: begin
          state_q <= (cnt_q < n_peers) ? ST_SC_CHK : ST_PICK_OUT;
        end
        ST_SC_CHK: begin
          if (avail) begin
            cur_ent_q <= ent_rd;
            state_q   <= ST_SC_WAIT;
          end else begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= ST_SC_RD;
          end
        end
        ST_SC_WAIT: begin
          if (sc_stat.done) begin
            // Strictly lower wins, so ties keep the lower index.
            if (!best_found_q || (score < best_score_q)) begin
              best_found_q <= 1'b1;
              best_score_q <= score;
              best_idx_q   <= cnt_q[PIW-1:0];
              best_ent_q   <= cur_ent_q;
            end
            cnt_q   <= cnt_q + CW'(1);
            state_q <= ST_SC_RD;
          end
        end
        ST_PICK_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_found_q <= best_found_q;
            m_peer_q  <= best_found_q ? 5'(best_idx_q) : 5'd0;
            state_q   <= ST_IDLE;
          end
        end
        ST_RP_CALC: begin
          upd_q   <= upd_d;
          mix_q   <= 28'(ent_rd.rtt) * 28'd7 + 28'(sample_q) * 28'd3;
          state_q <= ST_RP_WR;
        end
        ST_RP_WR: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  ucb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_PEERS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ucb_ln u_ln (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ln_req),
    .x_i    (pull_total_q),
    .stat_o (ln_stat),
    .lnq_o  (lnq)
  );

  ucb_score u_score (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (sc_req),
    .ent_i     (ent_rd),
    .lnq_i     (lnq),
    .explore_i (explore_q),
    .stat_o    (sc_stat),
    .score_o   (score)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_found_q;
  assign m_axis_tdata_o  = {3'd0, m_peer_q};

  `UCB_ASSERT(a_no_peer_zero, (m_valid_q && !m_found_q) |-> (m_peer_q == 5'd0), "empty pick with nonzero peer")
  `UCB_ASSERT(a_write_in_range, ram_we |-> (32'(ram_waddr) < 32'(n_peers)), "table write outside peers in use")
  `UCB_ASSERT_NEXT(a_pick_busy, in_fire && !s_axis_tuser_i, !s_axis_tready_o, "pick accepted but block idle")
  `UCB_ASSERT(a_ln_done_state, ln_stat.done |-> (state_q == ST_LN), "log unit finished outside its wait")
  `UCB_ASSERT(a_score_idle, sc_req.start |-> !sc_stat.busy, "score started while busy")
endmodule

// ===== src/ucb_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ucb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ===== src/ucb_ln.sv =====
// Iterative natural logarithm, floor(ln(x + 1) * 256), by normalize and square.
module ucb_ln (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ucb_pkg::unit_req_t           req_i,
  input  logic [31:0]                  x_i,
  output ucb_pkg::unit_stat_t          stat_o,
  output logic [ucb_pkg::LNQ_W-1:0]    lnq_o
);
  import ucb_pkg::*;

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_MLO, L_MHI} ln_state_e;

  ln_state_e   state_q;
  logic [32:0] m_q;
  logic [31:0] mant_q;
  logic [5:0]  k_q;
  logic [29:0] frac_q;
  logic [4:0]  i_q;
  logic [41:0] plo_q;
  logic        done_q;
  logic [LNQ_W-1:0] lnq_q;

  logic [63:0] sq;
  logic [32:0] sq_t;
  logic [35:0] lg;
  logic [42:0] phi;

  always_comb begin
    sq   = 64'(mant_q) * 64'(mant_q);
    sq_t = sq[63:31];
    lg   = {k_q, frac_q};
    phi  = 43'(lg[35:18] * LN2_Q24) + 43'(plo_q[41:18]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      m_q     <= '0;
      mant_q  <= '0;
      k_q     <= '0;
      frac_q  <= '0;
      i_q     <= '0;
      plo_q   <= '0;
      lnq_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            m_q     <= 33'(x_i) + 33'd1;
            k_q     <= 6'd32;
            frac_q  <= '0;
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          // Shift until the leading one sits at the top, counting the exponent down.
          if (m_q[32]) begin
            mant_q  <= m_q[32:1];
            i_q     <= '0;
            state_q <= L_SQ;
          end else begin
            m_q <= {m_q[31:0], 1'b0};
            k_q <= k_q - 6'd1;
          end
        end
        L_SQ: begin
          if (sq_t[32]) begin
            mant_q <= sq_t[32:1];
            frac_q[5'(5'd29 - i_q)] <= 1'b1;
          end else begin
            mant_q <= sq_t[31:0];
          end
          i_q <= i_q + 5'd1;
          if (i_q == 5'd29) begin
            state_q <= L_MLO;
          end
        end
        L_MLO: begin
          plo_q   <= 42'(lg[17:0] * LN2_Q24);
          state_q <= L_MHI;
        end
        L_MHI: begin
          lnq_q   <= LNQ_W'(phi >> 28);
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign lnq_o       = lnq_q;
  assign stat_o.done = done_q;
  assign stat_o.busy = (state_q != L_IDLE);
endmodule

// ===== src/ucb_score.sv =====
// Iterative score of one peer: base cost minus the exploration bonus.
module ucb_score (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ucb_pkg::unit_req_t                 req_i,
  input  ucb_pkg::entry_t                    ent_i,
  input  logic [ucb_pkg::LNQ_W-1:0]          lnq_i,
  input  logic [ucb_pkg::ES_W-1:0]           explore_i,
  output ucb_pkg::unit_stat_t                stat_o,
  output logic signed [ucb_pkg::SCORE_W-1:0] score_o
);
  import ucb_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_DIV, C_SQRT, C_MUL} sc_state_e;

  sc_state_e         state_q;
  logic [3:0]        cnt_q;
  logic [LNQ_W-1:0]  dvd_q;
  logic [LNQ_W:0]    rem_q;
  logic [32:0]       dsr_q;
  logic [SQRT_W-1:0] v_q;
  logic [SQRT_W-1:0] res_q;
  logic [SQRT_W-1:0] bit_q;
  logic [26:0]       base_q;
  logic              done_q;
  logic signed [SCORE_W-1:0] score_q;

  logic [RTT_W-1:0]  rtt_eff;
  logic [SUCC_W-1:0] sr;
  logic [29:0]       fail_cost;
  logic [23:0]       load_cost;
  logic [26:0]       base_d;
  logic [LNQ_W:0]    r_sh;
  logic              ge;
  logic [SQRT_W-1:0] rb;
  logic [35:0]       bonus_p;

  always_comb begin
    rtt_eff   = (ent_i.rtt == '0) ? RTT_EMPTY : ent_i.rtt;
    sr        = (ent_i.succ > SUCC_ONE) ? SUCC_ONE : ent_i.succ;
    fail_cost = 30'(SUCC_ONE - sr) * 30'd5000;
    load_cost = 24'(ent_i.infl) * 24'd51200;
    base_d    = 27'(rtt_eff) + 27'(fail_cost >> 8) + 27'(load_cost);
    r_sh      = {rem_q[LNQ_W-1:0], dvd_q[LNQ_W-1]};
    ge        = (33'(r_sh) >= dsr_q);
    rb        = res_q + bit_q;
    bonus_p   = 36'(explore_i) * 36'(res_q[ROOT_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      dvd_q   <= '0;
      rem_q   <= '0;
      dsr_q   <= '0;
      v_q     <= '0;
      res_q   <= '0;
      bit_q   <= '0;
      base_q  <= '0;
      score_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (req_i.start) begin
            base_q  <= base_d;
            dvd_q   <= lnq_i;
            rem_q   <= '0;
            dsr_q   <= 33'(ent_i.calls) + 33'd1;
            cnt_q   <= 4'd15;
            state_q <= C_DIV;
          end
        end
        C_DIV: begin
          // Restoring division, one quotient bit per cycle.
          rem_q <= ge ? (r_sh - dsr_q[LNQ_W:0]) : r_sh;
          dvd_q <= {dvd_q[LNQ_W-2:0], ge};
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == '0) begin
            state_q <= C_SQRT;
          end
        end
        C_SQRT: begin
          if (cnt_q == 4'd15) begin
            v_q   <= {dvd_q, 8'd0};
            res_q <= '0;
            bit_q <= SQRT_W'(1) << (SQRT_W - 2);
            cnt_q <= 4'd11;
          end else begin
            if (v_q >= rb) begin
              v_q   <= v_q - rb;
              res_q <= (res_q >> 1) + bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
            cnt_q <= cnt_q - 4'd1;
            if (cnt_q == '0) begin
              state_q <= C_MUL;
            end
          end
        end
        C_MUL: begin
          score_q <= $signed(SCORE_W'(base_q)) - $signed(SCORE_W'(bonus_p >> 8));
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign score_o     = score_q;
  assign stat_o.done = done_q;
  assign stat_o.busy = (state_q != C_IDLE);
endmodule
